[rtl/sgibc_pkg.sv]
`default_nettype none
package sgibc_pkg;

  localparam int SAMPLE_BITS       = 16;
  localparam int MAX_STILL_SAMPLES = 1024;

  localparam int THR_W     = 12;
  localparam int CNT_W     = 11;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  localparam int ACC_W      = SAMPLE_BITS + $clog2(MAX_STILL_SAMPLES);
  localparam int AXES       = 6;
  localparam int AXIS_W     = 3;
  localparam int STEP_W     = $clog2(ACC_W);
  localparam int Q_W        = SAMPLE_BITS + 1;
  localparam int SQ_W       = 2 * SAMPLE_BITS;
  localparam int ROOT_ARG_W = 30;
  localparam int SQRT_STEPS = 15;
  localparam int ZDIFF_W    = SAMPLE_BITS + 2;

  localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_SAMPLES = 1'b1;

  localparam logic [THR_W-1:0] THR_RESET  = THR_W'(48);
  localparam logic [CNT_W-1:0] REQ_RESET  = CNT_W'(400);
  localparam logic [CNT_W-1:0] NEED_MAX   = CNT_W'(MAX_STILL_SAMPLES);
  localparam logic [SQ_W-1:0]  Q28_ONE    = SQ_W'(64'h1000_0000);

  localparam logic [AXIS_W-1:0] AXIS_ACCEL_X = AXIS_W'(3);
  localparam logic [AXIS_W-1:0] AXIS_ACCEL_Y = AXIS_W'(4);
  localparam logic [AXIS_W-1:0] AXIS_ACCEL_Z = AXIS_W'(5);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic              load_in;
    logic              eval;
    logic              div_init;
    logic              div_step;
    logic              div_store;
    logic              sq_first;
    logic              sq_second;
    logic              sqrt_init;
    logic              sqrt_step;
    logic              z_store;
    logic              load_out;
    logic [AXIS_W-1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic calibrated;
    logic reached;
  } status_t;

endpackage
`default_nettype wire

[rtl/stillness_gated_imu_bias_calibrator.sv]
`default_nettype none
// Stillness-gated IMU bias calibrator. One transaction in is one gyro (Q4 dps) and accel
// (Q14 g) sample; one transaction out reports done, the still run length and the six
// offsets. While no gyro axis moves by more than motion_threshold from the prior sample,
// all axes are summed; once required_samples still samples are seen the rounded means are
// latched, gravity is taken off accel z, and later samples are ignored until reset.
// An ordinary sample passes from acceptance to its result through load, evaluate, check and
// output. The sample that completes calibration also runs six rounding divides on one
// shared restoring divider, two squarings on one multiplier, and a bit-pair square root.
// A new sample is accepted while a finished result still waits in the output register.
module stillness_gated_imu_bias_calibrator (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     cfg_we_i,
  input  wire logic [sgibc_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [sgibc_pkg::CFG_W-1:0]              cfg_data_i,
  input  wire logic                                     in_valid_i,
  output logic                                          in_stall_o,
  input  wire logic signed [sgibc_pkg::SAMPLE_BITS-1:0] gyro_x_rate_i,
  input  wire logic signed [sgibc_pkg::SAMPLE_BITS-1:0] gyro_y_rate_i,
  input  wire logic signed [sgibc_pkg::SAMPLE_BITS-1:0] gyro_z_rate_i,
  input  wire logic signed [sgibc_pkg::SAMPLE_BITS-1:0] accel_x_value_i,
  input  wire logic signed [sgibc_pkg::SAMPLE_BITS-1:0] accel_y_value_i,
  input  wire logic signed [sgibc_pkg::SAMPLE_BITS-1:0] accel_z_value_i,
  output logic                                          out_valid_o,
  input  wire logic                                     out_stall_i,
  output logic                                          calibration_done_o,
  output logic [sgibc_pkg::CNT_W-1:0]                   still_run_length_o,
  output logic signed [sgibc_pkg::SAMPLE_BITS-1:0]      gyro_x_bias_o,
  output logic signed [sgibc_pkg::SAMPLE_BITS-1:0]      gyro_y_bias_o,
  output logic signed [sgibc_pkg::SAMPLE_BITS-1:0]      gyro_z_bias_o,
  output logic signed [sgibc_pkg::SAMPLE_BITS-1:0]      accel_x_bias_o,
  output logic signed [sgibc_pkg::SAMPLE_BITS-1:0]      accel_y_bias_o,
  output logic signed [sgibc_pkg::SAMPLE_BITS-1:0]      accel_z_bias_o
);
  import sgibc_pkg::*;

  cmd_t    cmd;
  status_t status;

  sgibc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sgibc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .gyro_x_rate_i      (gyro_x_rate_i),
    .gyro_y_rate_i      (gyro_y_rate_i),
    .gyro_z_rate_i      (gyro_z_rate_i),
    .accel_x_value_i    (accel_x_value_i),
    .accel_y_value_i    (accel_y_value_i),
    .accel_z_value_i    (accel_z_value_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .calibration_done_o (calibration_done_o),
    .still_run_length_o (still_run_length_o),
    .gyro_x_bias_o      (gyro_x_bias_o),
    .gyro_y_bias_o      (gyro_y_bias_o),
    .gyro_z_bias_o      (gyro_z_bias_o),
    .accel_x_bias_o     (accel_x_bias_o),
    .accel_y_bias_o     (accel_y_bias_o),
    .accel_z_bias_o     (accel_z_bias_o)
  );

endmodule
`default_nettype wire

[rtl/sgibc_ctrl.sv]
`default_nettype none
module sgibc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire sgibc_pkg::status_t status_i,
  output sgibc_pkg::cmd_t        cmd_o
);
  import sgibc_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_EVAL      = 4'd1;
  localparam logic [3:0] S_CHECK     = 4'd2;
  localparam logic [3:0] S_DIV_INIT  = 4'd3;
  localparam logic [3:0] S_DIV       = 4'd4;
  localparam logic [3:0] S_DIV_STORE = 4'd5;
  localparam logic [3:0] S_SQ_X      = 4'd6;
  localparam logic [3:0] S_SQ_Y      = 4'd7;
  localparam logic [3:0] S_SQRT_INIT = 4'd8;
  localparam logic [3:0] S_SQRT      = 4'd9;
  localparam logic [3:0] S_ZFIX      = 4'd10;
  localparam logic [3:0] S_OUT       = 4'd11;

  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(ACC_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);
  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXES - 1);

  logic [3:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [AXIS_W-1:0] axis_q, axis_d;
  logic              out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    axis_d  = axis_q;
    cmd_o   = '0;
    cmd_o.axis = axis_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = status_i.calibrated ? S_OUT : S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        axis_d  = '0;
        state_d = status_i.reached ? S_DIV_INIT : S_OUT;
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        step_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == DIV_LAST) begin
          state_d = S_DIV_STORE;
        end
      end
      S_DIV_STORE: begin
        cmd_o.div_store = 1'b1;
        if (axis_q == AXIS_LAST) begin
          state_d = S_SQ_X;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_DIV_INIT;
        end
      end
      S_SQ_X: begin
        cmd_o.sq_first = 1'b1;
        state_d = S_SQ_Y;
      end
      S_SQ_Y: begin
        cmd_o.sq_second = 1'b1;
        state_d = S_SQRT_INIT;
      end
      S_SQRT_INIT: begin
        cmd_o.sqrt_init = 1'b1;
        step_d  = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == SQRT_LAST) begin
          state_d = S_ZFIX;
        end
      end
      S_ZFIX: begin
        cmd_o.z_store = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

[rtl/sgibc_dp.sv]
`default_nettype none
module sgibc_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [sgibc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [sgibc_pkg::CFG_W-1:0]          cfg_data_i,
  input  wire logic signed [sgibc_pkg::SAMPLE_BITS-1:0] gyro_x_rate_i,
  input  wire logic signed [sgibc_pkg::SAMPLE_BITS-1:0] gyro_y_rate_i,
  input  wire logic signed [sgibc_pkg::SAMPLE_BITS-1:0] gyro_z_rate_i,
  input  wire logic signed [sgibc_pkg::SAMPLE_BITS-1:0] accel_x_value_i,
  input  wire logic signed [sgibc_pkg::SAMPLE_BITS-1:0] accel_y_value_i,
  input  wire logic signed [sgibc_pkg::SAMPLE_BITS-1:0] accel_z_value_i,
  input  wire sgibc_pkg::cmd_t                      cmd_i,
  output sgibc_pkg::status_t                        status_o,
  output logic                                      calibration_done_o,
  output logic [sgibc_pkg::CNT_W-1:0]               still_run_length_o,
  output logic signed [sgibc_pkg::SAMPLE_BITS-1:0]  gyro_x_bias_o,
  output logic signed [sgibc_pkg::SAMPLE_BITS-1:0]  gyro_y_bias_o,
  output logic signed [sgibc_pkg::SAMPLE_BITS-1:0]  gyro_z_bias_o,
  output logic signed [sgibc_pkg::SAMPLE_BITS-1:0]  accel_x_bias_o,
  output logic signed [sgibc_pkg::SAMPLE_BITS-1:0]  accel_y_bias_o,
  output logic signed [sgibc_pkg::SAMPLE_BITS-1:0]  accel_z_bias_o
);
  import sgibc_pkg::*;

  localparam logic signed [ZDIFF_W-1:0] Z_MAX = ZDIFF_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ZDIFF_W-1:0] Z_MIN = -ZDIFF_W'(1 << (SAMPLE_BITS - 1));

  logic [THR_W-1:0] thr_q;
  logic [CNT_W-1:0] req_q;

  sample_t                 in_q   [AXES];
  sample_t                 prev_q [3];
  logic signed [ACC_W-1:0] acc_q  [AXES];
  logic [CNT_W-1:0]        count_q;
  logic                    calibrated_q;
  sample_t                 bias_q [AXES];

  logic [ACC_W-1:0]        quo_q;
  logic [CNT_W-1:0]        rem_q;
  logic                    neg_q;
  logic [SQ_W-1:0]         sq_q;
  logic [ROOT_ARG_W-1:0]   arg_q, root_q, bit_q;

  logic                    out_done_q;
  logic [CNT_W-1:0]        out_len_q;
  sample_t                 out_bias_q [AXES];

  // stillness check
  logic [Q_W-1:0] gdiff [3];
  logic [Q_W-1:0] gmag  [3];
  logic           still;

  always_comb begin
    still = 1'b1;
    for (int i = 0; i < 3; i++) begin
      gdiff[i] = {in_q[i][SAMPLE_BITS-1], in_q[i]} - {prev_q[i][SAMPLE_BITS-1], prev_q[i]};
      gmag[i]  = gdiff[i][Q_W-1] ? (~gdiff[i] + 1'b1) : gdiff[i];
      if (gmag[i] > Q_W'(thr_q)) begin
        still = 1'b0;
      end
    end
  end

  logic [CNT_W-1:0] need;
  always_comb begin
    if (req_q == '0) begin
      need = CNT_W'(1);
    end else if (req_q > NEED_MAX) begin
      need = NEED_MAX;
    end else begin
      need = req_q;
    end
  end

  assign status_o.reached    = (count_q >= need);
  assign status_o.calibrated = calibrated_q;

  // rounding divider
  logic signed [ACC_W-1:0] acc_sel;
  logic [ACC_W-1:0]        acc_mag;
  logic [ACC_W-1:0]        dividend;
  logic [CNT_W:0]          rem_sh;
  logic                    rem_ge;
  logic [Q_W-1:0]          quo_mag;
  logic [Q_W-1:0]          quo_res;

  assign acc_sel  = acc_q[cmd_i.axis];
  assign acc_mag  = acc_sel[ACC_W-1] ? (~acc_sel + 1'b1) : acc_sel;
  assign dividend = acc_mag + ACC_W'(count_q >> 1);
  assign rem_sh   = {rem_q, quo_q[ACC_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, count_q});
  assign quo_mag  = quo_q[Q_W-1:0];
  assign quo_res  = neg_q ? (~quo_mag + 1'b1) : quo_mag;

  // gravity root
  logic [SAMPLE_BITS-1:0]  mul_op;
  logic [SQ_W-1:0]         prod;
  sample_t                 mul_src;
  logic [ROOT_ARG_W-1:0]   trial;
  logic [SAMPLE_BITS-1:0]  root_rnd;
  logic signed [ZDIFF_W-1:0] zdiff;
  sample_t                 zsat;

  assign mul_src  = cmd_i.sq_second ? bias_q[AXIS_ACCEL_Y] : bias_q[AXIS_ACCEL_X];
  assign mul_op   = mul_src[SAMPLE_BITS-1] ? (~mul_src + 1'b1) : mul_src;
  assign prod     = SQ_W'(mul_op) * SQ_W'(mul_op);
  assign trial    = root_q + bit_q;
  assign root_rnd = root_q[SAMPLE_BITS-1:0] + SAMPLE_BITS'(arg_q > root_q);
  assign zdiff    = ZDIFF_W'(bias_q[AXIS_ACCEL_Z]) - $signed({2'b00, root_rnd});

  always_comb begin
    if (zdiff > Z_MAX) begin
      zsat = Z_MAX[SAMPLE_BITS-1:0];
    end else if (zdiff < Z_MIN) begin
      zsat = Z_MIN[SAMPLE_BITS-1:0];
    end else begin
      zsat = zdiff[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      req_q <= REQ_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MOTION_THRESHOLD: thr_q <= cfg_data_i[THR_W-1:0];
        REG_REQUIRED_SAMPLES: req_q <= cfg_data_i[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q[0] <= gyro_x_rate_i;
      in_q[1] <= gyro_y_rate_i;
      in_q[2] <= gyro_z_rate_i;
      in_q[3] <= accel_x_value_i;
      in_q[4] <= accel_y_value_i;
      in_q[5] <= accel_z_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        prev_q[i] <= '0;
      end
      for (int i = 0; i < AXES; i++) begin
        acc_q[i]  <= '0;
        bias_q[i] <= '0;
      end
      count_q      <= '0;
      calibrated_q <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        for (int i = 0; i < 3; i++) begin
          prev_q[i] <= in_q[i];
        end
        if (still) begin
          for (int i = 0; i < AXES; i++) begin
            acc_q[i] <= acc_q[i] + ACC_W'(in_q[i]);
          end
          count_q <= count_q + 1'b1;
        end else begin
          for (int i = 0; i < AXES; i++) begin
            acc_q[i] <= '0;
          end
          count_q <= '0;
        end
      end
      if (cmd_i.div_store) begin
        bias_q[cmd_i.axis] <= quo_res[SAMPLE_BITS-1:0];
      end
      if (cmd_i.z_store) begin
        bias_q[AXIS_ACCEL_Z] <= zsat;
        for (int i = 0; i < AXES; i++) begin
          acc_q[i] <= '0;
        end
        count_q      <= '0;
        calibrated_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      quo_q <= dividend;
      rem_q <= '0;
      neg_q <= acc_sel[ACC_W-1];
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[ACC_W-2:0], rem_ge};
      rem_q <= rem_ge ? CNT_W'(rem_sh - {1'b0, count_q}) : rem_sh[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_first) begin
      sq_q <= prod;
    end else if (cmd_i.sq_second) begin
      sq_q <= sq_q + prod;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      arg_q  <= (sq_q < Q28_ONE) ? ROOT_ARG_W'(Q28_ONE - sq_q) : '0;
      root_q <= '0;
      bit_q  <= ROOT_ARG_W'(Q28_ONE);
    end else if (cmd_i.sqrt_step) begin
      if (arg_q >= trial) begin
        arg_q  <= arg_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_done_q <= calibrated_q;
      out_len_q  <= count_q;
      for (int i = 0; i < AXES; i++) begin
        out_bias_q[i] <= bias_q[i];
      end
    end
  end

  assign calibration_done_o = out_done_q;
  assign still_run_length_o = out_len_q;
  assign gyro_x_bias_o      = out_bias_q[0];
  assign gyro_y_bias_o      = out_bias_q[1];
  assign gyro_z_bias_o      = out_bias_q[2];
  assign accel_x_bias_o     = out_bias_q[3];
  assign accel_y_bias_o     = out_bias_q[4];
  assign accel_z_bias_o     = out_bias_q[5];

endmodule
`default_nettype wire

[tb/stillness_gated_imu_bias_calibrator_test.sv]
`timescale 1ns / 1ps
module stillness_gated_imu_bias_calibrator_test;
  import sgibc_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int HOLD_CYCLES = 400;

  typedef sample_t [2:0] axis3_t;

  typedef struct packed {
    axis3_t gyro;
    axis3_t accel;
  } imu_sample_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] run_len;
    axis3_t           gyro_bias;
    axis3_t           accel_bias;
  } bias_report_t;

  typedef enum int { ACC_LEVEL, ACC_Z_FLOOR, ACC_TILTED, ACC_ANY } accel_profile_e;
  typedef enum int { CAL_NEED_ZERO, CAL_NEED_CLAMPED, CAL_NEED_SHORT } cal_mode_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   calibration_done_o;
  logic [CNT_W-1:0]       still_run_length_o;
  sample_t                gyro_x_bias_o, gyro_y_bias_o, gyro_z_bias_o;
  sample_t                accel_x_bias_o, accel_y_bias_o, accel_z_bias_o;

  imu_sample_t            offer = '0;
  sample_t                gyro_x_rate_i, gyro_y_rate_i, gyro_z_rate_i;
  sample_t                accel_x_value_i, accel_y_value_i, accel_z_value_i;

  assign gyro_x_rate_i   = offer.gyro[0];
  assign gyro_y_rate_i   = offer.gyro[1];
  assign gyro_z_rate_i   = offer.gyro[2];
  assign accel_x_value_i = offer.accel[0];
  assign accel_y_value_i = offer.accel[1];
  assign accel_z_value_i = offer.accel[2];

  stillness_gated_imu_bias_calibrator DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .gyro_x_rate_i      (gyro_x_rate_i),
    .gyro_y_rate_i      (gyro_y_rate_i),
    .gyro_z_rate_i      (gyro_z_rate_i),
    .accel_x_value_i    (accel_x_value_i),
    .accel_y_value_i    (accel_y_value_i),
    .accel_z_value_i    (accel_z_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .calibration_done_o (calibration_done_o),
    .still_run_length_o (still_run_length_o),
    .gyro_x_bias_o      (gyro_x_bias_o),
    .gyro_y_bias_o      (gyro_y_bias_o),
    .gyro_z_bias_o      (gyro_z_bias_o),
    .accel_x_bias_o     (accel_x_bias_o),
    .accel_y_bias_o     (accel_y_bias_o),
    .accel_z_bias_o     (accel_z_bias_o)
  );

  // predictor state and register copy
  logic [THR_W-1:0]        thr_setting = THR_RESET;
  logic [CNT_W-1:0]        req_setting = REQ_RESET;
  axis3_t                  rate_hist = '0;
  logic signed [ACC_W-1:0] rate_acc [3] = '{default: '0};
  logic signed [ACC_W-1:0] grav_acc [3] = '{default: '0};
  logic [CNT_W-1:0]        run_cnt = '0;
  logic                    cal_done = 1'b0;
  axis3_t                  rate_ofs = '0;
  axis3_t                  grav_ofs = '0;

  imu_sample_t  pending_samples [$];
  bias_report_t expected_reports [$];

  // stimulus shaping: mirrors the still run so early phases never latch
  axis3_t gen_prev = '0;
  int     gen_run = 0;
  bit     allow_cal = 1'b0;
  bit     steady = 1'b0;
  int     hold_token = 0;
  int     hold_seen = 0;
  int     hold_left = 0;

  int queued_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int error_count = 0;
  int cycle_count = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint mean_round(input longint total, input longint n);
    longint mag, q;
    mag = (total < 0) ? -total : total;
    q = (mag + n / 2) / n;
    return (total < 0) ? -q : q;
  endfunction

  function automatic longint q14_root(input longint arg);
    longint r, t, rem;
    r = 0;
    for (int b = 14; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= arg) r = t;
    end
    rem = arg - r * r;
    if (rem > r) r = r + 1;
    return r;
  endfunction

  task automatic clear_run();
    for (int i = 0; i < 3; i++) begin
      rate_acc[i] = '0;
      grav_acc[i] = '0;
    end
    run_cnt = '0;
  endtask

  task automatic calib_predict(input imu_sample_t s);
    longint       need, diff, ox, oy, zm, rt, zb, mag_sq;
    bit           still;
    bias_report_t r;
    if (!cal_done) begin
      need = longint'(req_setting);
      if (need < 1) need = 1;
      if (need > MAX_STILL_SAMPLES) need = MAX_STILL_SAMPLES;
      still = 1'b1;
      for (int i = 0; i < 3; i++) begin
        diff = longint'($signed(s.gyro[i])) - longint'($signed(rate_hist[i]));
        if (diff < 0) diff = -diff;
        if (diff > longint'(thr_setting)) still = 1'b0;
      end
      if (still) begin
        for (int i = 0; i < 3; i++) begin
          rate_acc[i] = rate_acc[i] + $signed(s.gyro[i]);
          grav_acc[i] = grav_acc[i] + $signed(s.accel[i]);
        end
        run_cnt = run_cnt + 1'b1;
      end else begin
        clear_run();
      end
      rate_hist = s.gyro;
      if (longint'(run_cnt) >= need) begin
        for (int i = 0; i < 3; i++)
          rate_ofs[i] = sample_t'(mean_round(longint'(rate_acc[i]), longint'(run_cnt)));
        ox = mean_round(longint'(grav_acc[0]), longint'(run_cnt));
        oy = mean_round(longint'(grav_acc[1]), longint'(run_cnt));
        zm = mean_round(longint'(grav_acc[2]), longint'(run_cnt));
        mag_sq = ox * ox + oy * oy;
        rt = 0;
        if (mag_sq < (longint'(1) << 28)) rt = q14_root((longint'(1) << 28) - mag_sq);
        zb = zm - rt;
        if (zb > 32767) zb = 32767;
        if (zb < -32768) zb = -32768;
        grav_ofs[0] = sample_t'(ox);
        grav_ofs[1] = sample_t'(oy);
        grav_ofs[2] = sample_t'(zb);
        clear_run();
        cal_done = 1'b1;
      end
    end
    r.done = cal_done;
    r.run_len = run_cnt;
    r.gyro_bias = rate_ofs;
    r.accel_bias = grav_ofs;
    expected_reports.push_back(r);
  endtask

  task automatic check_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
      error_count++;
    end
  endtask

  // input side: predict on each accepted transaction, then pick the next one
  always @(posedge clk_i) begin : drive_samples
    bit go;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        calib_predict(offer);
        sent_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        go = steady || ($urandom_range(0, 99) >= 21);
        if (go && pending_samples.size() != 0) begin
          offer <= pending_samples.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : drive_stall
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(0, 99) < 21);
    end
  end

  always @(posedge clk_i) begin : check_reports
    bias_report_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Test completed with failures");
      $finish;
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected output transaction, expected none, actual run %0d",
                 $time, still_run_length_o);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        checked_count++;
        check_field("calibration_done", longint'(want.done), longint'(calibration_done_o));
        check_field("still_run_length", longint'(want.run_len), longint'(still_run_length_o));
        check_field("gyro_x_bias", $signed(want.gyro_bias[0]), longint'(gyro_x_bias_o));
        check_field("gyro_y_bias", $signed(want.gyro_bias[1]), longint'(gyro_y_bias_o));
        check_field("gyro_z_bias", $signed(want.gyro_bias[2]), longint'(gyro_z_bias_o));
        check_field("accel_x_bias", $signed(want.accel_bias[0]), longint'(accel_x_bias_o));
        check_field("accel_y_bias", $signed(want.accel_bias[1]), longint'(accel_y_bias_o));
        check_field("accel_z_bias", $signed(want.accel_bias[2]), longint'(accel_z_bias_o));
      end
    end
  end

  function automatic sample_t clamp16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return sample_t'(v);
  endfunction

  function automatic sample_t rand16();
    return sample_t'($urandom_range(0, 65535));
  endfunction

  function automatic sample_t rand_near(input int center, input int spread);
    return clamp16(center + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic axis3_t rand_accel(input accel_profile_e prof);
    axis3_t a;
    case (prof)
      ACC_LEVEL: begin
        a[0] = rand_near(0, 600);
        a[1] = rand_near(0, 600);
        a[2] = rand_near(16384, 600);
      end
      ACC_Z_FLOOR: begin
        a[0] = rand_near(0, 150);
        a[1] = rand_near(0, 150);
        a[2] = rand_near(-32500, 268);
      end
      ACC_TILTED: begin
        a[0] = rand_near($urandom_range(0, 1) ? 24000 : -24000, 8700);
        a[1] = rand_near(0, 8000);
        a[2] = rand16();
      end
      default: begin
        a[0] = rand16();
        a[1] = rand16();
        a[2] = rand16();
      end
    endcase
    return a;
  endfunction

  task automatic gen_push(input imu_sample_t item);
    bit still;
    int d, need;
    need = (req_setting == 0) ? 1 : ((req_setting > MAX_STILL_SAMPLES) ?
                                     MAX_STILL_SAMPLES : int'(req_setting));
    still = 1'b1;
    for (int i = 0; i < 3; i++) begin
      d = int'($signed(item.gyro[i])) - int'($signed(gen_prev[i]));
      if (d < 0) d = -d;
      if (d > int'(thr_setting)) still = 1'b0;
    end
    if (still && !allow_cal && gen_run + 1 >= need) begin
      item.gyro[0] = ($signed(gen_prev[0]) >= 0) ? 16'sh8000 : 16'sh7fff;
      still = 1'b0;
    end
    gen_run = still ? gen_run + 1 : 0;
    gen_prev = item.gyro;
    pending_samples.push_back(item);
    queued_count++;
  endtask

  task automatic push_fixed(input int gx, input int gy, input int gz,
                            input int ax, input int ay, input int az);
    imu_sample_t it;
    it.gyro[0] = clamp16(gx);
    it.gyro[1] = clamp16(gy);
    it.gyro[2] = clamp16(gz);
    it.accel[0] = clamp16(ax);
    it.accel[1] = clamp16(ay);
    it.accel[2] = clamp16(az);
    gen_push(it);
  endtask

  task automatic gen_still_run(input int len, input accel_profile_e prof);
    imu_sample_t it;
    int step, thr;
    thr = int'(thr_setting);
    repeat (len) begin
      for (int i = 0; i < 3; i++) begin
        step = int'($urandom_range(0, 2 * thr)) - thr;
        if ($urandom_range(0, 3) == 0) step = $urandom_range(0, 1) ? thr : -thr;
        it.gyro[i] = clamp16(int'($signed(gen_prev[i])) + step);
      end
      it.accel = rand_accel(prof);
      gen_push(it);
    end
  endtask

  // one axis moves by exactly one more than the threshold
  task automatic gen_edge_break();
    imu_sample_t it;
    int k, v;
    k = $urandom_range(0, 2);
    it.gyro = gen_prev;
    v = int'($signed(gen_prev[k])) + int'(thr_setting) + 1;
    if (v > 32767) v = int'($signed(gen_prev[k])) - int'(thr_setting) - 1;
    it.gyro[k] = sample_t'(v);
    it.accel = rand_accel(ACC_ANY);
    gen_push(it);
  endtask

  task automatic gen_noise(input int n);
    imu_sample_t it;
    repeat (n) begin
      for (int i = 0; i < 3; i++) begin
        it.gyro[i] = rand16();
        it.accel[i] = rand16();
      end
      gen_push(it);
    end
  endtask

  task automatic gen_mix(input int n, input accel_profile_e prof);
    int target;
    target = queued_count + n;
    while (queued_count < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          gen_still_run($urandom_range(4, 60), prof);
          if ($urandom_range(0, 1)) gen_edge_break();
        end
        6, 7: gen_noise($urandom_range(1, 6));
        default: begin
          gen_still_run($urandom_range(1, 5), ACC_ANY);
          gen_edge_break();
        end
      endcase
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MOTION_THRESHOLD) thr_setting = val[THR_W-1:0];
    else req_setting = val[CNT_W-1:0];
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || expected_reports.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    cal_mode_e        mode;
    accel_profile_e   prof;
    int               run_len;
    int               mix_len;
    logic [CFG_W-1:0] req_val;

    // one latch per run: the seed picks the required count and the accel shape
    mode = cal_mode_e'($urandom_range(0, 2));
    prof = accel_profile_e'($urandom_range(0, 3));
    // the clamped latch alone needs over a thousand samples
    mix_len = (mode == CAL_NEED_CLAMPED) ? 0 : 170;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first sample against a zero history, threshold edges, full-scale values
    push_fixed(48, -48, 0, 0, 0, 16384);
    push_fixed(48, -48, 49, 32767, 32767, 32767);
    push_fixed(48, -48, 1, -32768, -32768, -32768);
    push_fixed(32767, 32767, 32767, 0, 0, 0);
    push_fixed(32767, 32767, 32767, 32767, -32768, 0);
    push_fixed(32767 - 48, 32767, 32767 - 48, -32768, 32767, -1);
    push_fixed(-32768, -32768, -32768, 1, -1, 1);
    push_fixed(-32768, -32768, -32768, -1, 1, -1);
    push_fixed(-32720, -32719, -32768, 100, 200, 300);
    push_fixed(-32720, -32719, -32768, 0, 0, 16384);
    push_fixed(-32672, -32719, -32816, 5, 5, 5);
    push_fixed(0, 0, 0, 0, 0, 0);
    push_fixed(-1, 1, -1, -16384, 16384, -16384);
    wait_drained();

    write_reg(REG_MOTION_THRESHOLD, '0);
    write_reg(REG_REQUIRED_SAMPLES, CFG_W'(1024));
    steady = 1'b1;
    gen_mix(mix_len, ACC_LEVEL);
    wait_drained();
    steady = 1'b0;

    write_reg(REG_MOTION_THRESHOLD, '1);
    write_reg(REG_REQUIRED_SAMPLES, '1);
    hold_token++;
    gen_mix(mix_len, ACC_ANY);
    wait_drained();

    write_reg(REG_MOTION_THRESHOLD, CFG_W'($urandom_range(1, 300)));
    write_reg(REG_REQUIRED_SAMPLES, CFG_W'($urandom_range(400, 1023)));
    gen_mix(mix_len, accel_profile_e'($urandom_range(0, 3)));
    wait_drained();

    write_reg(REG_MOTION_THRESHOLD, CFG_W'($urandom_range(0, 4095)));
    write_reg(REG_REQUIRED_SAMPLES, CFG_W'(1000));
    gen_mix(mix_len, accel_profile_e'($urandom_range(0, 3)));
    wait_drained();

    write_reg(REG_MOTION_THRESHOLD, CFG_W'($urandom_range(0, 4095)));
    case (mode)
      CAL_NEED_ZERO: begin
        req_val = '0;
        run_len = 3;
      end
      CAL_NEED_CLAMPED: begin
        req_val = '1;
        run_len = MAX_STILL_SAMPLES + 3;
      end
      default: begin
        req_val = CFG_W'($urandom_range(1, 64));
        run_len = int'(req_val) + 3;
      end
    endcase
    write_reg(REG_REQUIRED_SAMPLES, req_val);
    allow_cal = 1'b1;
    steady = (mode == CAL_NEED_CLAMPED);
    hold_token++;
    gen_still_run(run_len, prof);
    gen_noise(20);
    wait_drained();
    steady = 1'b0;

    // latched values must survive new samples and register writes
    write_reg(REG_MOTION_THRESHOLD, '0);
    write_reg(REG_REQUIRED_SAMPLES, CFG_W'(1));
    gen_noise(30);
    gen_still_run(10, ACC_ANY);
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d samples (still runs, threshold-edge breaks, noise); checked %0d reports",
             sent_count, checked_count);
    $display("Latch mode %s with accel shape %s, offsets latched %0d, mismatches %0d",
             mode.name(), prof.name(), cal_done, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
